>>> rtl/core/crc32s_pkg.sv
// ----------------------------------------------------------------------------
// crc32s_pkg
// Shared types and constants of the sliced CRC-32 stream block.
// ----------------------------------------------------------------------------
package crc32s_pkg;

   localparam int unsigned CRC_W      = 32;
   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned MAX_BYTES  = 8;
   localparam int unsigned DATA_W     = MAX_BYTES * BYTE_W;
   localparam int unsigned COUNT_W    = 4;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;
   localparam logic [CRC_W-1:0]  POLY_RESET = 32'hEDB88320;
   localparam logic [CRC_W-1:0]  SEED_RESET = 32'h0000_0000;

   typedef logic [CRC_W-1:0] word_type;

   // Table contribution of each single set bit of a byte, bit i in word i.
   typedef logic [BYTE_W-1:0][CRC_W-1:0] basis_row_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLYNOMIAL = 1'b0,
      CSR_SEED       = 1'b1
   } csr_index_type;

endpackage

>>> rtl/core/crc32_slicing_stream.sv
// ----------------------------------------------------------------------------
// crc32_slicing_stream
// Reflected CRC-32 over up to eight bytes per transaction, programmable
// polynomial and seed.
//
// Usage: each request carries data bytes (byte 0 in bits 7:0, folded first),
// a byte count (values above BYTES_PER_ITEM are clamped) and a restart flag
// that reloads the hash from the seed first. Every request yields one
// response with the stored (complemented) CRC after its bytes.
// Pipeline: an accepted request is registered in the first stage, formed of the
// byte lanes and a registered partial sum; the merge of the running register
// and the output register form the second, which drives response valid.
// Throughput: one transaction per cycle while no table build or response
// stall holds it; running-register feedback closes within the second stage.
// Reset: the hash takes the seed reset value, the polynomial its reset
// value, and req_stall stays high while the slice basis is built. A
// polynomial write rebuilds it the same way.
// A stalled response holds; the first stage keeps taking a request while the
// output register is full, then req_stall rises.
// ----------------------------------------------------------------------------
module crc32_slicing_stream #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [crc32s_pkg::DATA_W-1:0]        req_data_bytes,
   input  logic [crc32s_pkg::COUNT_W-1:0]       req_byte_count,
   input  logic                                 req_restart,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [crc32s_pkg::CRC_W-1:0]         rsp_crc_value,
   input  logic                                 csr_write,
   input  logic [crc32s_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [crc32s_pkg::CRC_W-1:0]         csr_wdata
);
   import crc32s_pkg::*;

   localparam int CNT_W = $clog2(BYTES_PER_ITEM + 1);

   // configuration
   logic          poly_write;
   logic          seed_write;
   word_type      seed_ff;
   basis_row_type basis [BYTES_PER_ITEM];
   logic          build_busy;

   // stage 1
   logic [CNT_W-1:0] req_count;
   word_type         lane_slice [BYTES_PER_ITEM][BYTES_PER_ITEM];
   word_type         data_part;
   logic             accept;
   logic             a_valid_ff;
   word_type         a_data_part_ff;
   logic [CNT_W-1:0] a_count_ff;
   logic             a_restart_ff;

   // stage 2
   logic     advance;
   word_type next_hash;
   word_type stored_hash_ff;
   logic     rsp_valid_ff;

   always_comb begin
      poly_write = 1'b0;
      seed_write = 1'b0;
      if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLYNOMIAL: poly_write = 1'b1;
            CSR_SEED:       seed_write = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (seed_write) begin
         seed_ff <= csr_wdata;
      end
   end

   crc32s_table_build #(
      .SLICES (BYTES_PER_ITEM)
   ) u_table_build (
      .clock      (clock),
      .reset      (reset),
      .poly_write (poly_write),
      .poly_data  (csr_wdata),
      .basis      (basis),
      .busy       (build_busy)
   );

   // clamp the count to the lane count
   assign req_count = (req_byte_count > COUNT_W'(BYTES_PER_ITEM))
                    ? CNT_W'(BYTES_PER_ITEM) : CNT_W'(req_byte_count);

   generate
      for (genvar k = 0; k < BYTES_PER_ITEM; k++) begin : g_lane
         crc32s_lane #(
            .SLICES (BYTES_PER_ITEM)
         ) u_lane (
            .lane_byte (req_data_bytes[k*BYTE_W +: BYTE_W] & BYTE_MASK),
            .basis     (basis),
            .slice_val (lane_slice[k])
         );
      end
   endgenerate

   // Data bytes at or above the count drop out here.
   always_comb begin
      word_type acc;
      acc = '0;
      for (int k = 0; k < BYTES_PER_ITEM; k++) begin
         for (int s = 0; s < BYTES_PER_ITEM; s++) begin
            if (int'(req_count) == k + s + 1) begin
               acc = acc ^ lane_slice[k][s];
            end
         end
      end
      data_part = acc;
   end

   assign advance   = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = build_busy || (a_valid_ff && !advance);
   assign accept    = req_valid && !req_stall;

   crc32s_merge #(
      .SLICES  (BYTES_PER_ITEM),
      .COUNT_W (CNT_W)
   ) u_merge (
      .stored_hash (stored_hash_ff),
      .seed        (seed_ff),
      .restart     (a_restart_ff),
      .count       (a_count_ff),
      .data_part   (a_data_part_ff),
      .basis       (basis),
      .next_hash   (next_hash)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         stored_hash_ff <= SEED_RESET;
      end else begin
         if (accept) begin
            a_valid_ff <= 1'b1;
         end else if (advance) begin
            a_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            stored_hash_ff <= next_hash;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_data_part_ff <= data_part;
         a_count_ff     <= req_count;
         a_restart_ff   <= req_restart;
      end
   end

   // The hash only moves with a response, so it doubles as the output register.
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = stored_hash_ff;

endmodule

>>> rtl/core/crc32s_table_build.sv
// ----------------------------------------------------------------------------
// crc32s_table_build
// Holds the polynomial and rebuilds the slice basis, one slice per cycle.
// ----------------------------------------------------------------------------
module crc32s_table_build #(
   parameter int SLICES = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       poly_write,
   input  crc32s_pkg::word_type       poly_data,
   output crc32s_pkg::basis_row_type  basis [SLICES],
   output logic                       busy
);
   import crc32s_pkg::*;

   localparam int ROW_W = (SLICES > 1) ? $clog2(SLICES) : 1;

   word_type       poly_ff;
   logic           busy_ff;
   logic [ROW_W-1:0] row_ff;
   basis_row_type  basis_ff [SLICES];

   basis_row_type  row0;
   basis_row_type  row_next;
   basis_row_type  row_in;

   // Slice 0: eight shift/xor steps of the reflected polynomial per bit.
   always_comb begin
      word_type e;
      for (int i = 0; i < BYTE_W; i++) begin
         e = CRC_W'(1) << i;
         for (int j = 0; j < BYTE_W; j++) begin
            e = (e >> 1) ^ (e[0] ? poly_ff : '0);
         end
         row0[i] = e;
      end
   end

   // Slice k: previous slice followed by one zero byte.
   generate
      if (SLICES > 1) begin : g_chain
         basis_row_type prev;
         assign prev = basis_ff[row_ff - ROW_W'(1)];
         always_comb begin
            word_type p;
            word_type f;
            for (int i = 0; i < BYTE_W; i++) begin
               p = prev[i];
               f = '0;
               for (int j = 0; j < BYTE_W; j++) begin
                  if (p[j]) begin
                     f = f ^ basis_ff[0][j];
                  end
               end
               row_next[i] = (p >> BYTE_W) ^ f;
            end
         end
      end else begin : g_single
         assign row_next = row0;
      end
   endgenerate

   assign row_in = (row_ff == '0) ? row0 : row_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end else if (poly_write) begin
         poly_ff <= poly_data;
         busy_ff <= 1'b1;
         row_ff  <= '0;
      end else if (busy_ff) begin
         basis_ff[row_ff] <= row_in;
         if (row_ff == ROW_W'(SLICES - 1)) begin
            busy_ff <= 1'b0;
         end else begin
            row_ff <= row_ff + ROW_W'(1);
         end
      end
   end

   assign basis = basis_ff;
   assign busy  = busy_ff;

endmodule

>>> rtl/core/crc32s_lane.sv
// ----------------------------------------------------------------------------
// crc32s_lane
// Table lookup of one byte in every slice, done as a GF(2) product.
// ----------------------------------------------------------------------------
module crc32s_lane #(
   parameter int SLICES = 8
) (
   input  logic [crc32s_pkg::BYTE_W-1:0] lane_byte,
   input  crc32s_pkg::basis_row_type     basis [SLICES],
   output crc32s_pkg::word_type          slice_val [SLICES]
);
   import crc32s_pkg::*;

   always_comb begin
      word_type acc;
      for (int s = 0; s < SLICES; s++) begin
         acc = '0;
         for (int i = 0; i < BYTE_W; i++) begin
            if (lane_byte[i]) begin
               acc = acc ^ basis[s][i];
            end
         end
         slice_val[s] = acc;
      end
   end

endmodule

>>> rtl/core/crc32s_merge.sv
// ----------------------------------------------------------------------------
// crc32s_merge
// Folds the running register into the lane sum and forms the new stored hash.
// ----------------------------------------------------------------------------
module crc32s_merge #(
   parameter int SLICES  = 8,
   parameter int COUNT_W = 4
) (
   input  crc32s_pkg::word_type       stored_hash,
   input  crc32s_pkg::word_type       seed,
   input  logic                       restart,
   input  logic [COUNT_W-1:0]         count,
   input  crc32s_pkg::word_type       data_part,
   input  crc32s_pkg::basis_row_type  basis [SLICES],
   output crc32s_pkg::word_type       next_hash
);
   import crc32s_pkg::*;

   localparam int CRC_LANES = (SLICES < 4) ? SLICES : 4;

   word_type crc;
   word_type crc_slice [CRC_LANES][SLICES];

   assign crc = ~(restart ? seed : stored_hash);

   generate
      for (genvar k = 0; k < CRC_LANES; k++) begin : g_lane
         crc32s_lane #(
            .SLICES (SLICES)
         ) u_lane (
            .lane_byte (crc[k*BYTE_W +: BYTE_W]),
            .basis     (basis),
            .slice_val (crc_slice[k])
         );
      end
   endgenerate

   always_comb begin
      word_type acc;
      acc = data_part;
      // Byte k of n uses the slice that still has n-1-k bytes to travel.
      for (int k = 0; k < CRC_LANES; k++) begin
         for (int s = 0; s < SLICES; s++) begin
            if (int'(count) == k + s + 1) begin
               acc = acc ^ crc_slice[k][s];
            end
         end
      end
      // Bytes of the register not consumed by a short transaction shift down.
      for (int m = 0; m <= SLICES; m++) begin
         if (int'(count) == m) begin
            acc = acc ^ (crc >> (BYTE_W * m));
         end
      end
      next_hash = ~acc;
   end

endmodule

>>> rtl/core/crc32s_checker.sv
// ----------------------------------------------------------------------------
// crc32s_checker
// Port-level checks of the sliced CRC-32 stream block.
// ----------------------------------------------------------------------------
module crc32s_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [crc32s_pkg::CRC_W-1:0]      rsp_crc_value,
   input logic                              csr_write,
   input logic [crc32s_pkg::CSR_IDX_W-1:0]  csr_index
);
   import crc32s_pkg::*;

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value))
      else $error("stalled response changed");

   // table build after reset blocks requests
   a_reset_build: assert property (@(posedge clock)
      reset |=> req_stall)
      else $error("request taken during table build after reset");

   // polynomial write blocks requests while the tables rebuild
   a_poly_build: assert property (@(posedge clock) disable iff (reset)
      csr_write && (csr_index == CSR_POLYNOMIAL) |=> req_stall)
      else $error("request taken during table rebuild");

   // a fresh response comes from a request accepted into the first stage
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("response without matching request");

endmodule

bind crc32_slicing_stream crc32s_checker u_checker (.*);
